@@ rtl/kdms_pkg.sv @@
// Shared types, constants and saturation helper for the depth smoother.
`default_nettype none
package kdms_pkg;

   // Median window capacity and filter constants in signed Q16.16.
   localparam int MAX_WINDOW_DEF = 16;
   localparam logic signed [31:0] FX_ONE  = 32'sd65536;
   localparam logic signed [31:0] Q_DIAG  = 32'sd190054;
   localparam logic signed [31:0] P_START = 32'sd655360;
   localparam logic [31:0] R_RESET = 32'd19661;
   localparam logic [4:0]  W_RESET = 5'd5;

   // Configuration register indexes.
   localparam logic [1:0] CSR_NOISE  = 2'd0;
   localparam logic [1:0] CSR_WINDOW = 2'd1;

   localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
   localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

   // One request as queued between the front end and the filter.
   typedef struct packed {
      logic              start;
      logic signed [31:0] depth;
   } req_item_type;

   // One corrected estimate handed from the filter to the median stage.
   typedef struct packed {
      logic              start;
      logic signed [31:0] est;
   } est_item_type;

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7fffffff;
      end else if (v < SAT_LO) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/kalman_depth_median_smoother.sv @@
// Top level of the depth smoother: request queue, Kalman filter, median stage.
// The filter takes one sample at a time: accept, predict, and for each of
// the two measurements a setup step, four gain divisions and twenty multiply,
// round and apply updates, then the hand-off; a skipped measurement omits those.
// Synchronous active-high reset restores the filter state and the registers.
`default_nettype none
module kalman_depth_median_smoother
   import kdms_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // depth_sample
   input  wire logic [0:0]  req_tuser,   // start_req
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // smoothed_depth, filtered_estimate
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   logic [31:0]  measurement_noise_ff;
   logic [4:0]   window_size_ff;
   logic         item_valid, item_ready;
   req_item_type item;
   logic         est_valid, est_ready;
   est_item_type est_item;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         measurement_noise_ff <= R_RESET;
         window_size_ff       <= W_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NOISE:  measurement_noise_ff <= csr_wdata;
            CSR_WINDOW: window_size_ff       <= csr_wdata[4:0];
            default: begin
            end
         endcase
      end
   end

   kdms_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready)
   );

   kdms_filter u_filter (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (item_valid),
      .item              (item),
      .item_ready        (item_ready),
      .measurement_noise (measurement_noise_ff),
      .est_valid         (est_valid),
      .est_item          (est_item),
      .est_ready         (est_ready)
   );

   kdms_median #(.MAX_WINDOW(MAX_WINDOW)) u_median (
      .clock       (clock),
      .reset       (reset),
      .est_valid   (est_valid),
      .est_item    (est_item),
      .est_ready   (est_ready),
      .window_size (window_size_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
`default_nettype wire

@@ rtl/kdms_front.sv @@
// Front end: accepts requests, decodes the start flag and queues them.
`default_nettype none
module kdms_front
   import kdms_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,   // depth_sample
   input  wire logic [0:0]   req_tuser,   // start_req
   output logic              item_valid,
   output req_item_type      item,
   input  wire logic         item_ready
);

   req_item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   assign req_tready = (fill_ff != 2'd2);
   assign item_valid = (fill_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = item_valid && item_ready;

   // Queue pointer and occupancy bookkeeping.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the request, classifying it by its start flag.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff].start <= req_tuser[0];
         slot_ff[wr_ptr_ff].depth <= $signed(req_tdata);
      end
   end

endmodule
`default_nettype wire

@@ rtl/kdms_divider.sv @@
// Restoring divider for the Kalman gain, one quotient bit per cycle.
`default_nettype none
module kdms_divider
   import kdms_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [47:0] mag,
   input  wire logic [32:0] den,
   input  wire logic        neg,
   output logic             done,
   output logic signed [31:0] quot
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [33:0] rem_ff;
   logic [31:0] low_ff;
   logic [31:0] q_ff;
   logic [33:0] d_ff;
   logic        ovf_ff;
   logic        neg_ff;
   logic [49:0] num_w;
   logic [33:0] dd_w;
   logic [34:0] trial_w;
   logic        fits_w;

   // Rounded quotient (2*mag + den) / (2*den).
   assign num_w   = {1'b0, mag, 1'b0} + {17'b0, den};
   assign dd_w    = {den, 1'b0};
   assign trial_w = {rem_ff, low_ff[31]};
   assign fits_w  = (trial_w >= {1'b0, d_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Quotient datapath: the top bits seed the remainder, the low 32 shift in.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {16'b0, num_w[49:32]};
         low_ff <= num_w[31:0];
         d_ff   <= dd_w;
         ovf_ff <= ({16'b0, num_w[49:32]} >= dd_w);
         neg_ff <= neg;
         q_ff   <= 32'd0;
      end else if (busy_ff) begin
         low_ff <= {low_ff[30:0], 1'b0};
         q_ff   <= {q_ff[30:0], fits_w};
         if (fits_w) begin
            rem_ff <= 34'(trial_w - {1'b0, d_ff});
         end else begin
            rem_ff <= trial_w[33:0];
         end
      end
   end

   // Apply the sign and saturate to signed 32 bits.
   always_comb begin
      if (neg_ff) begin
         if (ovf_ff || (q_ff > 32'h8000_0000)) begin
            quot = 32'sh80000000;
         end else begin
            quot = $signed(32'd0 - q_ff);
         end
      end else begin
         if (ovf_ff || q_ff[31]) begin
            quot = 32'sh7fffffff;
         end else begin
            quot = $signed(q_ff);
         end
      end
   end

   assign done = done_ff;

endmodule
`default_nettype wire

@@ rtl/kdms_filter.sv @@
// Kalman predict and correct sequencer with one shared multiplier.
`default_nettype none
module kdms_filter
   import kdms_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         item_valid,
   input  wire req_item_type item,
   output logic              item_ready,
   input  wire logic [31:0]  measurement_noise,
   output logic              est_valid,
   output est_item_type      est_item,
   input  wire logic         est_ready
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PRED  = 4'd1;
   localparam logic [3:0] S_LATCH = 4'd2;
   localparam logic [3:0] S_DSET  = 4'd3;
   localparam logic [3:0] S_DIV   = 4'd4;
   localparam logic [3:0] S_MUL   = 4'd5;
   localparam logic [3:0] S_RND   = 4'd6;
   localparam logic [3:0] S_APPLY = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;
   localparam logic [4:0] LAST_UPD = 5'd19;

   logic [3:0] state_ff, state_in;
   logic signed [31:0] x_ff [4];
   logic signed [31:0] p_ff [16];
   logic signed [31:0] depth_ff;
   logic               start_ff;
   logic               m_ff;
   logic [1:0]         k_ff;
   logic [4:0]         u_ff;
   logic [32:0]        s_ff;
   logic signed [31:0] y_ff;
   logic signed [31:0] row_ff [4];
   logic signed [31:0] col_ff [4];
   logic signed [31:0] gain_ff [4];
   logic signed [63:0] prod_ff;
   logic [47:0]        rmag_ff;
   logic               rneg_ff;

   logic signed [31:0] pp_w [16];
   logic signed [33:0] a_w [16];
   logic signed [31:0] pmm_w, xm_w, z_w;
   logic signed [33:0] s_w;
   logic               skip_w;
   logic signed [32:0] diff_w;
   logic signed [31:0] y_w;
   logic signed [31:0] colk_w;
   logic [31:0]        cmag_w;
   logic               div_done;
   logic signed [31:0] div_quot;
   logic [3:0]         pidx_w;
   logic               is_x_w;
   logic signed [31:0] op_a_w, op_b_w, old_w;
   logic [63:0]        pmag_w;
   logic [63:0]        prnd_w;
   logic signed [49:0] upd_w;
   logic signed [31:0] new_w;
   logic               sub_w;

   // Predict step: P' = F P F^T + Q, evaluated element by element.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            a_w[i*4+j] = {{2{p_ff[i*4+j][31]}}, p_ff[i*4+j]};
            if (i < 2) begin
               a_w[i*4+j] = a_w[i*4+j] + {{2{p_ff[(i+2)*4+j][31]}}, p_ff[(i+2)*4+j]};
            end
         end
      end
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            pp_w[i*4+j] = sat32({{16{a_w[i*4+j][33]}}, a_w[i*4+j]}
                                + ((j < 2) ? {{16{a_w[i*4+j+2][33]}}, a_w[i*4+j+2]} : 50'sd0)
                                + ((i == j) ? {{18{Q_DIAG[31]}}, Q_DIAG} : 50'sd0));
         end
      end
   end

   // Innovation variance and residual for the current measurement.
   always_comb begin
      pmm_w  = m_ff ? p_ff[5] : p_ff[0];
      xm_w   = m_ff ? x_ff[1] : x_ff[0];
      z_w    = m_ff ? FX_ONE : depth_ff;
      s_w    = {{2{pmm_w[31]}}, pmm_w} + $signed({2'b00, measurement_noise});
      skip_w = s_w[33] || (s_w == 34'sd0);
      diff_w = {z_w[31], z_w} - {xm_w[31], xm_w};
      y_w    = sat32({{17{diff_w[32]}}, diff_w});
   end

   // Gain numerator for the divider.
   assign colk_w = col_ff[k_ff];
   assign cmag_w = colk_w[31] ? (32'd0 - colk_w) : colk_w;

   kdms_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_DSET),
      .mag   ({cmag_w, 16'b0}),
      .den   (s_ff),
      .neg   (colk_w[31]),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Update operands: four state terms, then sixteen covariance terms.
   always_comb begin
      pidx_w = 4'(u_ff - 5'd4);
      is_x_w = (u_ff < 5'd4);
      op_a_w = is_x_w ? gain_ff[u_ff[1:0]] : gain_ff[pidx_w[3:2]];
      op_b_w = is_x_w ? y_ff : row_ff[pidx_w[1:0]];
      old_w  = is_x_w ? x_ff[u_ff[1:0]] : p_ff[pidx_w];
      pmag_w = prod_ff[63] ? (64'd0 - prod_ff) : prod_ff;
      prnd_w = pmag_w + 64'd32768;
      sub_w  = is_x_w ? rneg_ff : !rneg_ff;
      if (sub_w) begin
         upd_w = {{18{old_w[31]}}, old_w} - $signed({2'b00, rmag_ff});
      end else begin
         upd_w = {{18{old_w[31]}}, old_w} + $signed({2'b00, rmag_ff});
      end
      new_w = sat32(upd_w);
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (item_valid) state_in = S_PRED;
         S_PRED:  state_in = S_LATCH;
         S_LATCH: begin
            if (!skip_w) begin
               state_in = S_DSET;
            end else if (!m_ff) begin
               state_in = S_LATCH;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DSET:  state_in = S_DIV;
         S_DIV: begin
            if (div_done) state_in = (k_ff == 2'd3) ? S_MUL : S_DSET;
         end
         S_MUL:   state_in = S_RND;
         S_RND:   state_in = S_APPLY;
         S_APPLY: begin
            if (u_ff != LAST_UPD) begin
               state_in = S_MUL;
            end else begin
               state_in = m_ff ? S_DONE : S_LATCH;
            end
         end
         S_DONE:  if (est_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Filter state: reset and start reload, predict, and the update writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff[0] <= 32'sd0;
         x_ff[1] <= FX_ONE;
         x_ff[2] <= 32'sd0;
         x_ff[3] <= 32'sd0;
         for (int i = 0; i < 16; i++) begin
            p_ff[i] <= ((i % 5) == 0) ? P_START : 32'sd0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (item_valid && item.start) begin
                  x_ff[0] <= item.depth;
                  x_ff[1] <= FX_ONE;
                  x_ff[2] <= 32'sd0;
                  x_ff[3] <= 32'sd0;
                  for (int i = 0; i < 16; i++) begin
                     p_ff[i] <= ((i % 5) == 0) ? P_START : 32'sd0;
                  end
               end
            end
            S_PRED: begin
               x_ff[0] <= sat32({{18{x_ff[0][31]}}, x_ff[0]} + {{18{x_ff[2][31]}}, x_ff[2]});
               x_ff[1] <= sat32({{18{x_ff[1][31]}}, x_ff[1]} + {{18{x_ff[3][31]}}, x_ff[3]});
               for (int i = 0; i < 16; i++) begin
                  p_ff[i] <= pp_w[i];
               end
            end
            S_APPLY: begin
               if (is_x_w) begin
                  x_ff[u_ff[1:0]] <= new_w;
               end else begin
                  p_ff[pidx_w] <= new_w;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Working registers of the correction.
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            depth_ff <= item.depth;
            start_ff <= item.start;
            m_ff     <= 1'b0;
         end
         S_LATCH: begin
            s_ff <= s_w[32:0];
            y_ff <= y_w;
            k_ff <= 2'd0;
            for (int j = 0; j < 4; j++) begin
               row_ff[j] <= m_ff ? p_ff[4+j] : p_ff[j];
               col_ff[j] <= m_ff ? p_ff[j*4+1] : p_ff[j*4];
            end
            if (skip_w) m_ff <= 1'b1;
         end
         S_DIV: begin
            if (div_done) begin
               gain_ff[k_ff] <= div_quot;
               k_ff <= k_ff + 2'd1;
               u_ff <= 5'd0;
            end
         end
         S_MUL: prod_ff <= op_a_w * op_b_w;
         S_RND: begin
            rmag_ff <= prnd_w[63:16];
            rneg_ff <= prod_ff[63];
         end
         S_APPLY: begin
            u_ff <= u_ff + 5'd1;
            if (u_ff == LAST_UPD) m_ff <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign item_ready     = (state_ff == S_IDLE);
   assign est_valid      = (state_ff == S_DONE);
   assign est_item.start = start_ff;
   assign est_item.est   = x_ff[0];

endmodule
`default_nettype wire

@@ rtl/kdms_median.sv @@
// Estimate history ring and upper median by insertion into a sorted row.
`default_nettype none
module kdms_median
   import kdms_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         est_valid,
   input  wire est_item_type est_item,
   output logic              est_ready,
   input  wire logic [4:0]   window_size,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata    // smoothed_depth, filtered_estimate
);

   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_WINDOW - 1);
   localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_WINDOW);

   localparam logic [1:0] M_IDLE  = 2'd0;
   localparam logic [1:0] M_READ  = 2'd1;
   localparam logic [1:0] M_SHIFT = 2'd2;
   localparam logic [1:0] M_OUT   = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic signed [31:0] hist_mem [MAX_WINDOW];
   logic signed [31:0] rdata_ff;
   logic [IDX_W-1:0]   head_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   n_ff;
   logic [IDX_W-1:0]   rptr_ff;
   logic [CNT_W-1:0]   issued_ff;
   logic               rdv_ff;
   logic [CNT_W-1:0]   fc_ff;
   logic [CNT_W-1:0]   sh_ff;
   logic signed [31:0] sorted_ff [MAX_WINDOW];
   logic signed [31:0] ins_w [MAX_WINDOW];
   logic               gt_w [MAX_WINDOW];
   logic signed [31:0] est_ff;
   logic               rsp_valid_ff;
   logic [63:0]        rsp_data_ff;

   logic               accept;
   logic               issue;
   logic               out_free;
   logic [CNT_W-1:0]   w_eff;
   logic [IDX_W-1:0]   base_head;
   logic [CNT_W-1:0]   base_cnt;
   logic [CNT_W:0]     cnt1;
   logic [CNT_W-1:0]   new_cnt;

   assign est_ready = (state_ff == M_IDLE);
   assign accept    = est_valid && est_ready;
   assign issue     = (state_ff == M_READ) && (issued_ff != n_ff);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Effective window, held within one and the history depth.
   always_comb begin
      if (window_size == 5'd0) begin
         w_eff = CNT_W'(1);
      end else if (int'(window_size) > MAX_WINDOW) begin
         w_eff = MAX_CNT;
      end else begin
         w_eff = CNT_W'(window_size);
      end
      base_head = est_item.start ? '0 : head_ff;
      base_cnt  = est_item.start ? '0 : count_ff;
      cnt1      = {1'b0, base_cnt} + {{CNT_W{1'b0}}, 1'b1};
      new_cnt   = (cnt1 > {1'b0, w_eff}) ? w_eff : cnt1[CNT_W-1:0];
   end

   // Insert the value just read into the sorted row.
   always_comb begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
         gt_w[k] = (CNT_W'(k) >= fc_ff) || (sorted_ff[k] > rdata_ff);
      end
      for (int k = 0; k < MAX_WINDOW; k++) begin
         if (!gt_w[k]) begin
            ins_w[k] = sorted_ff[k];
         end else if (k == 0) begin
            ins_w[k] = rdata_ff;
         end else if (!gt_w[k-1]) begin
            ins_w[k] = rdata_ff;
         end else begin
            ins_w[k] = sorted_ff[k-1];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         M_IDLE:  if (accept) state_in = M_READ;
         M_READ:  if ((issued_ff == n_ff) && !rdv_ff) state_in = M_SHIFT;
         M_SHIFT: if (sh_ff == (n_ff >> 1)) state_in = M_OUT;
         M_OUT:   if (out_free) state_in = M_IDLE;
         default: state_in = M_IDLE;
      endcase
   end

   // Control state and the history pointers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= M_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rdv_ff   <= issue;
         if (accept) begin
            head_ff  <= (base_head == LAST_IDX) ? '0 : base_head + 1'b1;
            count_ff <= new_cnt;
         end
         if ((state_ff == M_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // History memory, one write and one registered read port.
   always_ff @(posedge clock) begin
      if (accept) begin
         hist_mem[base_head] <= est_item.est;
      end
      rdata_ff <= hist_mem[rptr_ff];
   end

   // Gather, sort and step to the middle element.
   always_ff @(posedge clock) begin
      case (state_ff)
         M_IDLE: begin
            if (accept) begin
               est_ff    <= est_item.est;
               n_ff      <= new_cnt;
               rptr_ff   <= base_head;
               issued_ff <= '0;
               fc_ff     <= '0;
               sh_ff     <= '0;
            end
         end
         M_READ: begin
            if (issue) begin
               rptr_ff   <= (rptr_ff == '0) ? LAST_IDX : rptr_ff - 1'b1;
               issued_ff <= issued_ff + 1'b1;
            end
            if (rdv_ff) begin
               fc_ff <= fc_ff + 1'b1;
               for (int k = 0; k < MAX_WINDOW; k++) begin
                  sorted_ff[k] <= ins_w[k];
               end
            end
         end
         M_SHIFT: begin
            if (sh_ff != (n_ff >> 1)) begin
               sh_ff <= sh_ff + 1'b1;
               for (int k = 0; k < MAX_WINDOW - 1; k++) begin
                  sorted_ff[k] <= sorted_ff[k+1];
               end
            end
         end
         M_OUT: begin
            if (out_free) begin
               rsp_data_ff <= {est_ff, sorted_ff[0]};
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // The history never holds more entries than it has room for.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= MAX_WINDOW)
      else $error("history count beyond depth");

   // The ring head stays inside the memory.
   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      int'(head_ff) < MAX_WINDOW)
      else $error("history head beyond depth");

   // The sorted row never receives more values than were requested.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != M_IDLE) |-> (fc_ff <= n_ff) && (issued_ff <= n_ff))
      else $error("sorted row overfilled");
`endif

endmodule
`default_nettype wire
